>>> hw/rtl/wfsa_pkg.sv
// Package for the worst-fit segment allocator: sizes, types and codes.
// Used by every module of the block; depends on nothing.
`default_nettype none
package wfsa_pkg;
  localparam int unsigned MaxSeg   = 32;
  localparam int unsigned AddrBits = 16;
  localparam int unsigned IdBits   = 8;
  localparam int unsigned SizeBits = AddrBits + 1;
  localparam int unsigned IdxBits  = $clog2(MaxSeg);
  localparam int unsigned CntBits  = $clog2(MaxSeg + 1);
  localparam int unsigned TotBits  = 17;

  localparam logic [SizeBits-1:0] MemLimit = SizeBits'(1) << AddrBits;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_DECIDE, S_MERGE, S_OUT
  } state_e;

  typedef struct packed {
    logic                used;
    logic [AddrBits-1:0] start;
    logic [SizeBits-1:0] size;
    logic                free;
    logic [IdBits-1:0]   owner;
  } seg_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                init;
    logic [SizeBits-1:0] init_size;
    logic                split;
    logic                take;
    logic                clear;
    logic [IdxBits-1:0]  pos;
    logic [SizeBits-1:0] req;
    logic [IdBits-1:0]   owner;
    logic                merge;
  } cmd_t;

  // Running worst-fit / owner-search result passed along the chain.
  typedef struct packed {
    logic                fit_hit;
    logic [IdxBits-1:0]  fit_idx;
    logic [SizeBits-1:0] fit_size;
    logic                own_hit;
    logic [IdxBits-1:0]  own_idx;
    logic [AddrBits-1:0] own_start;
  } scan_t;
endpackage
`default_nettype wire

>>> hw/rtl/wfsa_cell.sv
// One table entry of the allocator chain plus its stage of the search chain.
// Depends on wfsa_pkg.
`default_nettype none
module wfsa_cell
  import wfsa_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [IdxBits-1:0] idx_i,
  input  wire cmd_t               cmd_i,
  input  wire logic [SizeBits-1:0] req_i,
  input  wire logic [IdBits-1:0]  owner_i,
  input  wire seg_t               prev_i,
  input  wire seg_t               next_i,
  input  wire logic               next_merge_i,
  output seg_t                    seg_o,
  output logic                    merge_o,
  input  wire scan_t              scan_i,
  output scan_t                   scan_o
);
  seg_t  seg_q, seg_d;
  scan_t scan_q, scan_d;

  assign seg_o   = seg_q;
  assign scan_o  = scan_q;
  // Absorbs its right neighbor when both are free.
  assign merge_o = seg_q.used && seg_q.free && next_i.used && next_i.free;

  // Search stage: one cell per cycle.
  always_comb begin
    scan_d = scan_i;
    if (seg_q.used && seg_q.free && seg_q.size >= req_i &&
        (!scan_i.fit_hit || seg_q.size > scan_i.fit_size)) begin
      scan_d.fit_hit  = 1'b1;
      scan_d.fit_idx  = idx_i;
      scan_d.fit_size = seg_q.size;
    end
    if (!scan_i.own_hit && seg_q.used && !seg_q.free && seg_q.owner == owner_i) begin
      scan_d.own_hit   = 1'b1;
      scan_d.own_idx   = idx_i;
      scan_d.own_start = seg_q.start;
    end
  end

  always_comb begin
    seg_d = seg_q;
    if (cmd_i.init) begin
      seg_d.used  = (idx_i == '0);
      seg_d.start = '0;
      seg_d.size  = cmd_i.init_size;
      seg_d.free  = 1'b1;
    end else if (cmd_i.split && idx_i > cmd_i.pos) begin
      if (idx_i == cmd_i.pos + IdxBits'(1)) begin
        seg_d.used  = 1'b1;
        seg_d.start = prev_i.start + AddrBits'(cmd_i.req);
        seg_d.size  = prev_i.size - cmd_i.req;
        seg_d.free  = 1'b1;
      end else begin
        seg_d = prev_i;
      end
    end else if (cmd_i.take && idx_i == cmd_i.pos) begin
      if (cmd_i.split) seg_d.size = cmd_i.req;
      seg_d.free  = 1'b0;
      seg_d.owner = cmd_i.owner;
    end else if (cmd_i.clear && idx_i == cmd_i.pos) begin
      seg_d.free  = 1'b1;
      seg_d.owner = '0;
    end else if (cmd_i.merge && idx_i == cmd_i.pos) begin
      if (merge_o) begin
        seg_d.size = seg_q.size + next_i.size;
        seg_d.used = 1'b1;
      end
    end else if (cmd_i.merge && idx_i > cmd_i.pos && next_merge_i) begin
      // entry at pos+1 was absorbed: shift left
      seg_d = next_i;
    end
    if (cmd_i.merge && idx_i == cmd_i.pos && !merge_o) seg_d = seg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q.used  <= (idx_i == '0);
      seg_q.start <= '0;
      seg_q.size  <= MemLimit;
      seg_q.free  <= 1'b1;
      seg_q.owner <= '0;
      scan_q      <= '0;
    end else begin
      seg_q  <= seg_d;
      scan_q <= scan_d;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/worst_fit_segment_allocator_top.sv
// Top level of the worst-fit segment allocator: chain of table cells and
// the request sequencer. Depends on wfsa_pkg and wfsa_cell.
`default_nettype none
// Usage:
//   s_axis carries one request word: tuser = kind (0 allocate, 1 free),
//   tdata = owner_id then request_size. m_axis returns one result word per
//   request: tdata = status, start_address, free_segment_count.
//   cfg_we_i/cfg_wdata_i write total_size while idle; it reinitializes the
//   table to one free segment (0 is taken as 1, above 65536 saturates).
//   The search ripples through the 32 cells one cell per cycle in S_FIND. An
//   allocate that fits updates the table in S_DECIDE, and every allocate then
//   goes to S_OUT. A free releases the segment in S_DECIDE, then in S_MERGE
//   merges one neighbor per cycle (at most 2) until no merge is left and
//   goes to S_OUT.
//   One request is in flight at a time; s_axis_tready is high only while
//   the sequencer is idle, so no new request is accepted until the
//   sequencer has returned from S_OUT to idle.
//   The output register holds the result until the receiver takes it; a
//   stalled receiver holds the sequencer only once the next result is ready
//   while the register is still full.
//   Reset gives a single free segment of 65536 units.
module worst_fit_segment_allocator_top
  import wfsa_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [16:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // [7:0] owner_id, [24:8] request_size
  input  wire logic        s_axis_tuser,  // [0] kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [1:0] status, [17:2] start_address,
                                          // [23:18] free_segment_count
);
  state_e state_q, state_d;
  logic                kind_q;
  logic [IdBits-1:0]   owner_q;
  logic [SizeBits-1:0] req_q;
  scan_t               hit_q;
  status_e             st_q, st_d;
  logic [AddrBits-1:0] addr_q, addr_d;
  logic [CntBits-1:0]  cyc_q, cyc_d;
  logic [23:0]         out_q;
  logic                ov_q;
  logic                out_free;
  cmd_t                cmd;
  logic [SizeBits-1:0] tot_d;

  seg_t  segs [MaxSeg];
  logic  mrg  [MaxSeg];
  scan_t scan [MaxSeg+1];
  logic [CntBits-1:0] cnt, nfree;
  logic               any_merge;
  logic [IdxBits-1:0] mpos;

  assign scan[0] = '0;

  for (genvar g = 0; g < MaxSeg; g++) begin : g_cell
    seg_t pv, nx;
    logic nm;
    if (g == 0) begin : g_first
      assign pv = '0;
    end else begin : g_mid
      assign pv = segs[g-1];
    end
    if (g == MaxSeg - 1) begin : g_last
      assign nx = '0;
    end else begin : g_nx
      assign nx = segs[g+1];
    end
    // true when the merge point lies strictly left of this cell
    assign nm = any_merge && (IdxBits'(g) > mpos);
    wfsa_cell u_cell (
      .clk_i, .rst_ni,
      .idx_i(IdxBits'(g)), .cmd_i(cmd), .req_i(req_q), .owner_i(owner_q),
      .prev_i(pv), .next_i(nx), .next_merge_i(nm),
      .seg_o(segs[g]), .merge_o(mrg[g]),
      .scan_i(scan[g]), .scan_o(scan[g+1])
    );
  end

  always_comb begin
    cnt = '0; nfree = '0; any_merge = 1'b0; mpos = '0;
    for (int i = 0; i < MaxSeg; i++) begin
      cnt   = cnt + CntBits'(segs[i].used);
      nfree = nfree + CntBits'(segs[i].used && segs[i].free);
    end
    for (int i = MaxSeg - 1; i >= 0; i--) begin
      if (mrg[i]) begin
        any_merge = 1'b1;
        mpos      = IdxBits'(i);
      end
    end
  end

  always_comb begin
    if (cfg_wdata_i == '0)       tot_d = SizeBits'(1);
    else if (cfg_wdata_i > MemLimit) tot_d = MemLimit;
    else                         tot_d = SizeBits'(cfg_wdata_i);
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !ov_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    addr_d  = addr_q;
    cyc_d   = '0;
    cmd     = '0;
    cmd.init      = cfg_we_i;
    cmd.init_size = tot_d;
    cmd.req       = req_q;
    cmd.owner     = owner_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_d = S_FIND;
      S_FIND: begin
        // wait until the search has passed the last cell
        cyc_d = cyc_q + CntBits'(1);
        if (cyc_q == CntBits'(MaxSeg)) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        addr_d = '0;
        if (!kind_q) begin
          if (req_q == '0 || !hit_q.fit_hit) begin
            st_d = ST_NO_FIT;
          end else if (hit_q.fit_size > req_q && cnt >= CntBits'(MaxSeg)) begin
            st_d = ST_FULL;
          end else begin
            st_d       = ST_OK;
            cmd.take   = 1'b1;
            cmd.split  = hit_q.fit_size > req_q;
            cmd.pos    = hit_q.fit_idx;
            addr_d     = segs[hit_q.fit_idx].start;
          end
          state_d = S_OUT;
        end else if (!hit_q.own_hit) begin
          st_d    = ST_NO_OWNER;
          state_d = S_OUT;
        end else begin
          st_d      = ST_OK;
          addr_d    = hit_q.own_start;
          cmd.clear = 1'b1;
          cmd.pos   = hit_q.own_idx;
          state_d   = S_MERGE;
        end
      end
      S_MERGE: begin
        if (any_merge) begin
          cmd.merge = 1'b1;
          cmd.pos   = mpos;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      st_q    <= ST_OK;
      cyc_q   <= '0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      cyc_q   <= cyc_d;
      if (state_q == S_OUT && out_free) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q  <= s_axis_tuser;
      owner_q <= s_axis_tdata[7:0];
      req_q   <= s_axis_tdata[24:8];
    end
    if (state_q == S_FIND) hit_q <= scan[MaxSeg];
    if (state_q == S_OUT && out_free) out_q <= {nfree, addr_q, st_q};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Testbench for worst_fit_segment_allocator_top: random and directed allocate/free
// requests, checked against an in-bench worst-fit table model. Depends on wfsa_pkg and the top.
`timescale 1ns / 100ps
module tb_top
  import wfsa_pkg::*;
();

  typedef struct packed {
    logic        kind;
    logic [7:0]  owner;
    logic [16:0] req;
  } request_t;

  typedef struct packed {
    logic [5:0]  nfree;
    logic [15:0] addr;
    logic [1:0]  status;
  } reply_t;

  localparam int unsigned WatchLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  worst_fit_segment_allocator_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // table model
  logic [AddrBits-1:0] tbl_start [MaxSeg];
  logic [SizeBits-1:0] tbl_size  [MaxSeg];
  logic                tbl_free  [MaxSeg];
  logic [IdBits-1:0]   tbl_owner [MaxSeg];
  int                  tbl_count;
  logic [SizeBits-1:0] mem_total;

  request_t pending_q[$];
  reply_t   reply_q[$];
  int       mismatches = 0;
  bit       quiet = 1'b1;
  bit       hold_rx = 1'b0;
  bit       hold_go = 1'b0;
  bit       gap_tx = 1'b0;
  int       idle_cycles = 0;

  function automatic void table_reset(logic [16:0] value);
    mem_total = (value == 0) ? 17'd1 : (value > MemLimit) ? MemLimit : value;
    for (int i = 0; i < MaxSeg; i++) begin
      tbl_start[i] = '0; tbl_size[i] = '0; tbl_free[i] = 1'b0; tbl_owner[i] = '0;
    end
    tbl_size[0] = mem_total;
    tbl_free[0] = 1'b1;
    tbl_count = 1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_start[i] = tbl_start[i+1]; tbl_size[i] = tbl_size[i+1];
      tbl_free[i] = tbl_free[i+1]; tbl_owner[i] = tbl_owner[i+1];
    end
    tbl_count--;
  endfunction

  function automatic reply_t allocate_or_free(request_t r);
    reply_t res;
    int best, hit, i;
    res = '0;
    res.status = ST_OK;
    if (!r.kind) begin
      best = -1;
      for (i = 0; i < tbl_count; i++)
        if (tbl_free[i] && tbl_size[i] >= r.req &&
            (best < 0 || tbl_size[i] > tbl_size[best])) best = i;
      if (r.req == 0 || best < 0) res.status = ST_NO_FIT;
      else begin
        if (tbl_size[best] > r.req) begin
          if (tbl_count >= MaxSeg) res.status = ST_FULL;
          else begin
            for (i = tbl_count; i > best + 1; i--) begin
              tbl_start[i] = tbl_start[i-1]; tbl_size[i] = tbl_size[i-1];
              tbl_free[i] = tbl_free[i-1]; tbl_owner[i] = tbl_owner[i-1];
            end
            tbl_start[best+1] = tbl_start[best] + r.req[15:0];
            tbl_size[best+1]  = tbl_size[best] - r.req;
            tbl_free[best+1]  = 1'b1;
            tbl_owner[best+1] = '0;
            tbl_size[best] = r.req;
            tbl_count++;
          end
        end
        if (res.status == ST_OK) begin
          tbl_free[best] = 1'b0;
          tbl_owner[best] = r.owner;
          res.addr = tbl_start[best];
        end
      end
    end else begin
      hit = -1;
      for (i = 0; i < tbl_count; i++)
        if (!tbl_free[i] && tbl_owner[i] == r.owner) begin
          hit = i;
          break;
        end
      if (hit < 0) res.status = ST_NO_OWNER;
      else begin
        res.addr = tbl_start[hit];
        tbl_free[hit] = 1'b1;
        tbl_owner[hit] = '0;
        i = 0;
        while (i + 1 < tbl_count) begin
          if (tbl_free[i] && tbl_free[i+1]) begin
            tbl_size[i] += tbl_size[i+1];
            drop_entry(i + 1);
          end else i++;
        end
      end
    end
    for (i = 0; i < tbl_count; i++) if (tbl_free[i]) res.nfree++;
    return res;
  endfunction

  function automatic request_t mk(bit k, logic [7:0] o, logic [16:0] s);
    request_t r;
    r.kind = k; r.owner = o; r.req = s;
    return r;
  endfunction

  function automatic logic [16:0] rand_size(logic [16:0] lim);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 3) return 17'($urandom);
    if (p < 6) return lim;
    if (p < 70) return 17'($urandom_range(1, (lim > 64) ? 64 : lim));
    return 17'($urandom_range(1, lim));
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      reply_q.push_back(allocate_or_free(
        request_t'({s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[24:8]})));
      pending_q.pop_front();
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (rst_ni && pending_q.size() > 0 && !(s_axis_tvalid && s_axis_tready &&
          pending_q.size() == 0) && !gap_tx && (quiet || $urandom_range(0, 99) >= 28)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_q[0].kind;
        s_axis_tdata  <= {7'b0, pending_q[0].req, pending_q[0].owner};
      end else s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    reply_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = reply_t'(m_axis_tdata);
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = reply_q.pop_front();
        if (got.status !== want.status || got.addr !== want.addr ||
            got.nfree !== want.nfree) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d addr=%0d nfree=%0d got st=%0d addr=%0d nfree=%0d",
                     want.status, want.addr, want.nfree, got.status, got.addr, got.nfree);
        end
      end
    end
    m_axis_tready <= rst_ni && !hold_rx && (quiet || $urandom_range(0, 99) >= 28);
  end

  // receiver hold-off, counted here
  initial begin
    wait (hold_go);
    hold_rx = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (pending_q.size() == 0 && reply_q.size() == 0) || hold_rx)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic drain();
    wait (pending_q.size() == 0);
    while (reply_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_total(logic [16:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    table_reset(value);
  endtask

  task automatic random_phase(int n, int owners);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 55)
        pending_q.push_back(mk(1'b0, 8'($urandom_range(0, owners - 1)),
                               rand_size(mem_total)));
      else
        pending_q.push_back(mk(1'b1, ($urandom_range(0, 19) == 0) ? 8'($urandom)
                               : 8'($urandom_range(0, owners - 1)), 17'($urandom)));
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    table_reset(17'd65536);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    pending_q.push_back(mk(1'b0, 8'd1, 17'd0));
    pending_q.push_back(mk(1'b0, 8'd1, 17'd65537));
    pending_q.push_back(mk(1'b0, 8'd1, 17'h1FFFF));
    pending_q.push_back(mk(1'b1, 8'd9, 17'd0));
    pending_q.push_back(mk(1'b0, 8'd255, 17'd100));
    pending_q.push_back(mk(1'b0, 8'd0, 17'd200));
    pending_q.push_back(mk(1'b0, 8'd255, 17'd1));
    pending_q.push_back(mk(1'b1, 8'd0, 17'h1FFFF));
    pending_q.push_back(mk(1'b1, 8'd255, 17'd0));
    pending_q.push_back(mk(1'b1, 8'd255, 17'd0));
    pending_q.push_back(mk(1'b1, 8'd255, 17'd0));
    pending_q.push_back(mk(1'b0, 8'd7, 17'd65536));
    pending_q.push_back(mk(1'b1, 8'd7, 17'd0));
    drain();

    // table full: one-unit allocations past a full table, then exact fit
    write_total(17'd40);
    for (int i = 0; i < 33; i++) pending_q.push_back(mk(1'b0, 8'(i), 17'd1));
    pending_q.push_back(mk(1'b0, 8'd50, 17'd9));
    pending_q.push_back(mk(1'b0, 8'd51, 17'd8));
    drain();

    write_total(17'd0);
    pending_q.push_back(mk(1'b0, 8'd3, 17'd2));
    pending_q.push_back(mk(1'b0, 8'd3, 17'd1));
    pending_q.push_back(mk(1'b1, 8'd3, 17'd0));
    drain();

    // receiver hold-off with the sender still offering
    write_total(17'd1000);
    quiet = 1'b1;
    random_phase(20, 6);
    hold_go = 1'b1;
    wait (hold_rx);
    wait (!hold_rx);
    drain();

    quiet = 1'b0;
    write_total(17'd65536);
    random_phase(680, 16);
    drain();
    write_total(17'd64);
    random_phase(400, 8);
    drain();
    write_total(17'($urandom_range(1, 65536)));
    random_phase(400, 24);
    // sender pause until all results are in
    wait (pending_q.size() < 200);
    gap_tx = 1'b1;
    while (reply_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    gap_tx = 1'b0;
    drain();
    write_total(17'd100001);
    quiet = 1'b1;
    random_phase(150, 12);
    drain();
    quiet = 1'b0;
    write_total(17'd1);
    random_phase(100, 4);
    drain();

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

>>> files.f
hw/rtl/wfsa_pkg.sv
hw/rtl/wfsa_cell.sv
hw/rtl/worst_fit_segment_allocator_top.sv
sim/tb_top.sv
